FILE: rtl/rht_pkg.sv
// shared types and codes of the reference-counted handle table
`timescale 1ns / 1ps

package rht_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned HDL_W  = 32;
  localparam int unsigned REFS_W = 16;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  // operation codes
  localparam logic [1:0] OP_RETAIN  = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_REMOVED   = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HDL_W-1:0]  handle;
    logic [REFS_W-1:0] refs;
  } entry_t;

endpackage

FILE: rtl/rht_cell.sv
// one table slot of the rotating entry ring
`timescale 1ns / 1ps

module rht_cell
  import rht_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  entry_t entry_q;

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/refcounted_handle_table.sv
// top level of the reference-counted handle table
`timescale 1ns / 1ps

// reference-counted handle table
// input channel: in_valid_i / in_ready_o with operation_i, key_i, handle_i
// (retain by key, add entry, release by handle). output channel:
// out_valid_o / out_ready_i with status_o, handle_out_o, remaining_refs_o,
// one result per input transfer, in order.
// the entries live in a ring of CAPACITY cells; during a turn the ring
// moves one slot per cycle, and slot 0 passes a small head unit that
// compares and rewrites it. retain, add and release take one full turn;
// a release that frees an entry other than the last live one takes a
// second turn to drop the last entry into the freed slot. an add into a
// full table and an unknown operation skip the turn.
// one item is in work at a time; the next transfer waits until the
// last item has left the finish state.
// a finished result sits in an output register; the next item is taken
// while it waits, and that item's result is held back until the register
// is free, so a stalled receiver stalls the input only then.
// reset empties the table at once (occupancy zero); the slot contents
// need no clearing since only live slots are ever read.
module refcounted_handle_table
  import rht_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [HDL_W-1:0]  handle_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [HDL_W-1:0]  handle_out_o,
  output logic [REFS_W-1:0] remaining_refs_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_MOVE   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // slot counter: index of the entry now at the head of the ring
  logic [IW-1:0] t_q, t_d;

  // latched request
  logic [1:0]       op_q;
  logic [KEY_W-1:0] key_q;
  logic [HDL_W-1:0] hdl_q;
  logic [OW-1:0]    n_q;

  // scan results
  logic              found_q, found_d;
  logic [IW-1:0]     match_q, match_d;
  logic [HDL_W-1:0]  res_hdl_q, res_hdl_d;
  logic [REFS_W-1:0] res_refs_q, res_refs_d;
  entry_t            last_q, last_d;

  logic [OW-1:0] occ_q, occ_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [HDL_W-1:0]  hout_q, hout_d;
  logic [REFS_W-1:0] rout_q, rout_d;

  // ring
  entry_t cell_out [CAPACITY];
  entry_t head;
  entry_t head_wr;
  logic   shift;

  assign head = cell_out[0];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_ring
    entry_t cell_in;
    if (k == CAPACITY - 1) begin : g_tail
      assign cell_in = head_wr;
    end else begin : g_mid
      assign cell_in = cell_out[k+1];
    end
    rht_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (cell_out[k])
    );
  end

  logic              accept_in;
  logic              last_step;
  logic              live;
  logic              is_last_idx;
  logic              out_free;
  logic              full;
  logic [REFS_W-1:0] refs_inc;
  logic [REFS_W-1:0] refs_dec;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept_in   = in_valid_i && in_ready_o;
  assign last_step   = (t_q == IW'(CAPACITY - 1));
  assign live        = (OW'(t_q) < n_q);
  assign is_last_idx = (n_q != '0) && (OW'(t_q) == n_q - OW'(1));
  assign out_free    = !out_valid_q || out_ready_i;
  assign full        = (n_q >= OW'(CAPACITY));
  assign refs_inc    = (head.refs == REFS_MAX) ? head.refs : head.refs + REFS_W'(1);
  assign refs_dec    = (head.refs != '0) ? head.refs - REFS_W'(1) : '0;

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    found_d     = found_q;
    match_d     = match_q;
    res_hdl_d   = res_hdl_q;
    res_refs_d  = res_refs_q;
    last_d      = last_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    hout_d      = hout_q;
    rout_d      = rout_q;
    shift       = 1'b0;
    head_wr     = head;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          t_d     = '0;
          found_d = 1'b0;
          // full add and unknown code need no walk over the table
          if ((operation_i == OP_RETAIN) || (operation_i == OP_RELEASE) ||
              ((operation_i == OP_ADD) && (occ_q < OW'(CAPACITY)))) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_SCAN: begin
        shift = 1'b1;
        if (is_last_idx) begin
          last_d = head;
        end
        priority if (op_q == OP_RETAIN) begin
          if (live && !found_q && (head.key == key_q)) begin
            found_d      = 1'b1;
            head_wr.refs = refs_inc;
            res_hdl_d    = head.handle;
            res_refs_d   = refs_inc;
          end
        end else if (op_q == OP_RELEASE) begin
          if (live && !found_q && (head.handle == hdl_q)) begin
            found_d      = 1'b1;
            match_d      = t_q;
            head_wr.refs = refs_dec;
            res_refs_d   = refs_dec;
          end
        end else begin
          // add: the new entry goes into the first free slot
          if (OW'(t_q) == n_q) begin
            head_wr.key    = key_q;
            head_wr.handle = hdl_q;
            head_wr.refs   = REFS_W'(1);
          end
        end

        t_d = t_q + IW'(1);
        if (last_step) begin
          t_d     = '0;
          state_d = ST_FINISH;
          if (op_q == OP_ADD) begin
            occ_d = n_q + OW'(1);
          end else if ((op_q == OP_RELEASE) && found_d && (res_refs_d == '0)) begin
            occ_d = n_q - OW'(1);
            // freed slot is not the last live one: refill it on a second turn
            if (OW'(match_d) != n_q - OW'(1)) begin
              state_d = ST_MOVE;
            end
          end
        end
      end

      ST_MOVE: begin
        shift = 1'b1;
        if (t_q == match_q) begin
          head_wr = last_q;
        end
        t_d = t_q + IW'(1);
        if (last_step) begin
          t_d     = '0;
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = STAT_NOT_FOUND;
          hout_d      = '0;
          rout_d      = '0;
          priority if (op_q == OP_RETAIN) begin
            if (found_q) begin
              status_d = STAT_OK;
              hout_d   = res_hdl_q;
              rout_d   = res_refs_q;
            end
          end else if (op_q == OP_ADD) begin
            if (full) begin
              status_d = STAT_FULL;
            end else begin
              status_d = STAT_OK;
              rout_d   = REFS_W'(1);
            end
          end else if (op_q == OP_RELEASE) begin
            if (found_q) begin
              if (res_refs_q != '0) begin
                status_d = STAT_OK;
                rout_d   = res_refs_q;
              end else begin
                status_d = STAT_REMOVED;
              end
            end
          end else begin
            status_d = STAT_NOT_FOUND;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t_q         <= '0;
      found_q     <= 1'b0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      found_q     <= found_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      op_q  <= operation_i;
      key_q <= key_i;
      hdl_q <= handle_i;
      n_q   <= occ_q;
    end
    match_q    <= match_d;
    res_hdl_q  <= res_hdl_d;
    res_refs_q <= res_refs_d;
    last_q     <= last_d;
    status_q   <= status_d;
    hout_q     <= hout_d;
    rout_q     <= rout_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign handle_out_o     = hout_q;
  assign remaining_refs_o = rout_q;

endmodule

FILE: rtl/rht_checker.sv
// port-level checks of the handle table, bound to the top level
`timescale 1ns / 1ps

module rht_checker
  import rht_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [HDL_W-1:0]  handle_out_o,
  input logic [REFS_W-1:0] remaining_refs_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(handle_out_o) && $stable(remaining_refs_o))
    else $error("stalled result changed");

  // one item in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // only a successful retain returns a handle
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> handle_out_o == '0)
    else $error("handle on failed result");

  // a removal reports no remaining references
  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_REMOVED) |-> remaining_refs_o == '0)
    else $error("removed entry with references");

  // a live entry never has a zero count
  a_ok_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_OK) |-> remaining_refs_o != '0)
    else $error("ok result with zero references");

endmodule

bind refcounted_handle_table rht_checker u_rht_checker (.*);

FILE: tb/testbench.sv
// self-checking testbench for the reference-counted handle table
`timescale 1ns / 1ps

module testbench;
  import rht_pkg::*;

  // table depth handed to the block and mirrored by the local table copy
  localparam int unsigned TABLE_DEPTH = 16;
  // the one operation code that carries no meaning
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  // slowest turn of the block: retain/add/release plus the compaction turn
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
  // several times the slowest correct run with the longest gaps on both sides
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned POOL_SIZE = 8;

  typedef struct packed {
    logic [1:0]        status;
    logic [HDL_W-1:0]  handle;
    logic [REFS_W-1:0] refs;
  } lookup_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        operation_i;
  logic [KEY_W-1:0]  key_i;
  logic [HDL_W-1:0]  handle_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [HDL_W-1:0]  handle_out_o;
  logic [REFS_W-1:0] remaining_refs_o;

  // local copy of the table, updated at each input transfer
  logic [KEY_W-1:0]  tbl_key  [TABLE_DEPTH];
  logic [HDL_W-1:0]  tbl_hdl  [TABLE_DEPTH];
  logic [REFS_W-1:0] tbl_refs [TABLE_DEPTH];
  int unsigned       tbl_count;

  // results owed by the block, oldest first
  lookup_result_t pending_results [$];

  // small pools so that duplicate keys and handles show up often
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [HDL_W-1:0] hdl_pool [POOL_SIZE];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  // gaps on both channels follow this switch
  bit          idle_enable;
  // long receiver hold-off, waited out and cleared by the receiver process
  int unsigned hold_request;

  refcounted_handle_table #(
    .CAPACITY (TABLE_DEPTH)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .key_i            (key_i),
    .handle_i         (handle_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .handle_out_o     (handle_out_o),
    .remaining_refs_o (remaining_refs_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run guard: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // table prediction: applies one operation to the local copy and returns
  // the result that the block owes for it
  // ---------------------------------------------------------------------
  function automatic lookup_result_t predict_table_op(logic [1:0] op,
                                                      logic [KEY_W-1:0] key,
                                                      logic [HDL_W-1:0] hdl);
    lookup_result_t res;
    int             hit;
    res.status = STAT_NOT_FOUND;
    res.handle = '0;
    res.refs   = '0;
    hit        = -1;
    case (op)
      OP_RETAIN: begin
        // first live entry with a matching key wins
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && tbl_key[i] == key) hit = i;
        end
        if (hit >= 0) begin
          // count saturates at its top value
          if (tbl_refs[hit] != REFS_MAX) tbl_refs[hit] = tbl_refs[hit] + 1'b1;
          res.status = STAT_OK;
          res.handle = tbl_hdl[hit];
          res.refs   = tbl_refs[hit];
        end
      end
      OP_ADD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          // add into a full table is dropped
          res.status = STAT_FULL;
        end else begin
          tbl_key[tbl_count]  = key;
          tbl_hdl[tbl_count]  = hdl;
          tbl_refs[tbl_count] = 1;
          tbl_count++;
          res.status = STAT_OK;
          res.refs   = 1;
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && tbl_hdl[i] == hdl) hit = i;
        end
        if (hit >= 0) begin
          if (tbl_refs[hit] != 0) tbl_refs[hit] = tbl_refs[hit] - 1'b1;
          if (tbl_refs[hit] != 0) begin
            res.status = STAT_OK;
            res.refs   = tbl_refs[hit];
          end else begin
            // freed slot takes the last live entry
            tbl_key[hit]  = tbl_key[tbl_count-1];
            tbl_hdl[hit]  = tbl_hdl[tbl_count-1];
            tbl_refs[hit] = tbl_refs[tbl_count-1];
            tbl_count--;
            res.status = STAT_REMOVED;
          end
        end
      end
      default: begin
        // undefined operation answers not found and changes nothing
      end
    endcase
    return res;
  endfunction

  // gap lengths: mostly short, now and then long
  function automatic int unsigned pick_gap(bit allow_zero);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_mismatch(string reason, lookup_result_t want, lookup_result_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected status %0d handle %h refs %0d, got status %0d handle %h refs %0d",
               $time, reason, want.status, want.handle, want.refs,
               seen.status, seen.handle, seen.refs);
    end
  endtask

  // ---------------------------------------------------------------------
  // result side: random ready, optional long hold-off
  // ---------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        // long hold-off so the block backs up into its input
        out_ready_i <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (pick_gap(1'b0)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // every result transfer is compared with the oldest owed result
  always @(posedge clk_i) begin : result_check
    lookup_result_t seen;
    lookup_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.status = status_o;
      seen.handle = handle_out_o;
      seen.refs   = remaining_refs_o;
      if (pending_results.size() == 0) begin
        want = '0;
        log_mismatch("result with nothing owed", want, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status || seen.handle !== want.handle ||
            seen.refs !== want.refs) begin
          log_mismatch("result differs", want, seen);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------

  // one request transfer; the expected result is queued at the transfer
  task automatic issue_request(logic [1:0] op, logic [KEY_W-1:0] key,
                               logic [HDL_W-1:0] hdl);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    handle_i    <= hdl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_table_op(op, key, hdl));
    gap = idle_enable ? pick_gap(1'b1) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender pauses until the block owes nothing
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] live_key();
    return tbl_key[$urandom_range(0, tbl_count - 1)];
  endfunction

  function automatic logic [HDL_W-1:0] live_handle();
    return tbl_hdl[$urandom_range(0, tbl_count - 1)];
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // lookups on an empty table and the undefined operation
  task automatic test_empty_table();
    issue_request(OP_RETAIN, 32'h0000_0000, 32'h0000_0000);
    issue_request(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(OP_UNDEFINED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // field extremes, duplicates, release to zero with and without compaction
  task automatic test_basic_ops();
    issue_request(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_request(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
    // found handle of zero still reads status ok
    issue_request(OP_RETAIN, 32'hFFFF_FFFF, 32'h5555_5555);
    issue_request(OP_RETAIN, 32'h0000_0000, 32'hAAAA_AAAA);
    issue_request(OP_RELEASE, 32'h1234_5678, 32'hFFFF_FFFF);
    // last live entry removed, nothing moves
    issue_request(OP_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    // duplicate keys: retain must hit the first one
    issue_request(OP_ADD, 32'h0000_0005, 32'h0000_00A0);
    issue_request(OP_ADD, 32'h0000_0005, 32'h0000_00B0);
    issue_request(OP_RETAIN, 32'h0000_0005, 32'h0);
    // entry 0 goes to zero, last entry fills its slot
    issue_request(OP_RELEASE, 32'h0, 32'h0000_0000);
    issue_request(OP_RELEASE, 32'h0, 32'h0000_0000);
    issue_request(OP_RETAIN, 32'h0000_0005, 32'h0);
    issue_request(OP_UNDEFINED, $urandom, $urandom);
  endtask

  // fill to capacity, overflow, free a middle slot, refill
  task automatic test_full_table();
    while (tbl_count < TABLE_DEPTH) begin
      issue_request(OP_ADD, $urandom, 32'h1000_0000 + tbl_count);
    end
    issue_request(OP_ADD, $urandom, $urandom);
    issue_request(OP_RELEASE, $urandom, tbl_hdl[2]);
    issue_request(OP_ADD, $urandom, $urandom);
    issue_request(OP_ADD, $urandom, $urandom);
    issue_request(OP_RELEASE, $urandom, tbl_hdl[TABLE_DEPTH-1]);
  endtask

  // receiver holds off long while requests keep coming, then a full drain
  task automatic test_output_backpressure();
    hold_request = 300;
    idle_enable  = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (tbl_count > 0 && i[0]) issue_request(OP_RETAIN, live_key(), $urandom);
      else issue_request(OP_ADD, key_pool[i % POOL_SIZE], $urandom);
    end
    idle_enable = 1'b1;
    wait_all_results();
  endtask

  // random traffic, mostly aimed at live entries; weights per phase
  task automatic test_random_traffic(int unsigned num_items, int unsigned add_w,
                                     int unsigned retain_w, bit gaps_on);
    int unsigned      done;
    int unsigned      r;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] hdl;
    done        = 0;
    idle_enable = gaps_on;
    while (done < num_items) begin
      r   = $urandom_range(0, 99);
      key = $urandom;
      hdl = $urandom;
      if (r < 3) begin
        // noise: undefined operation, not counted
        op = OP_UNDEFINED;
      end else if (r < 3 + add_w) begin
        op = OP_ADD;
        if ($urandom_range(0, 1)) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 9) < 4) hdl = hdl_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (r < 3 + add_w + retain_w) begin
        op = OP_RETAIN;
        if (tbl_count > 0 && $urandom_range(0, 99) < 85) key = live_key();
      end else begin
        op = OP_RELEASE;
        if (tbl_count > 0 && $urandom_range(0, 99) < 85) hdl = live_handle();
      end
      issue_request(op, key, hdl);
      if (op != OP_UNDEFINED) done++;
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OP_RETAIN;
    key_i          = '0;
    handle_i       = '0;
    tbl_count      = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_enable    = 1'b1;
    hold_request   = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      hdl_pool[i] = $urandom;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_random_traffic(400, 60, 20, 1'b1);
    test_output_backpressure();
    test_random_traffic(600, 30, 35, 1'b1);
    test_random_traffic(150, 30, 35, 1'b0);
    test_random_traffic(450, 20, 20, 1'b1);
    test_random_traffic(200, 45, 25, 1'b1);

    // drain, then give the block time to show any stray result
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
